// ===== hw/rtl/p2p_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the point-to-plane RMS error block.
package p2p_pkg;

  localparam int MaxPairs   = 65536;
  localparam int CoordBits  = 32;
  localparam int CoordShift = 32 - CoordBits;
  localparam int CntW       = $clog2(MaxPairs + 1);
  localparam int DiffW      = 33;
  localparam int NormW      = 16;
  localparam int AccW       = 51;
  localparam int QDepth     = 2;
  localparam int QAw        = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW      = $clog2(QDepth + 1);
  localparam int DivSteps   = 64;
  localparam int SqrtSteps  = 32;
  localparam int StepW      = $clog2(DivSteps);

  typedef struct packed {
    logic signed [31:0] src_x;
    logic signed [31:0] src_y;
    logic signed [31:0] src_z;
    logic signed [31:0] tgt_x;
    logic signed [31:0] tgt_y;
    logic signed [31:0] tgt_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               is_last;
  } item_t;

  typedef struct packed {
    logic [31:0] rms_error;
    logic [16:0] pair_count;
    logic        saturated;
  } result_t;

  // One classified correspondence as it waits for the accumulator.
  typedef struct packed {
    logic signed [DiffW-1:0] d_x;
    logic signed [DiffW-1:0] d_y;
    logic signed [DiffW-1:0] d_z;
    logic signed [NormW-1:0] n_x;
    logic signed [NormW-1:0] n_y;
    logic signed [NormW-1:0] n_z;
    logic                    keep;
    logic                    last;
    logic [CntW-1:0]         count;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic            start;
    logic [63:0]     sum;
    logic [CntW-1:0] count;
  } fin_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } fin_rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_ROUND,
    BK_SQ,
    BK_ADD,
    BK_LAUNCH,
    BK_WAIT
  } back_state_t;

  typedef enum logic [1:0] {
    FIN_IDLE,
    FIN_DIV,
    FIN_SQRT
  } fin_state_t;

  // Keep the low CoordBits bits of a coordinate, sign-extended.
  function automatic logic signed [31:0] coord_ext(logic [31:0] v);
    logic signed [31:0] t;
    t = signed'(v << CoordShift);
    return t >>> CoordShift;
  endfunction

endpackage

// ===== hw/rtl/p2p_queue.sv =====
`timescale 1ns / 1ps
// Small queue of classified words between the front and the accumulator.
module p2p_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  p2p_pkg::entry_t  wdata,
  input  logic             pop,
  output p2p_pkg::entry_t  rdata,
  output p2p_pkg::q_stat_t stat
);
  import p2p_pkg::*;

  entry_t            mem [QDepth];
  logic [QAw-1:0]    wptr;
  logic [QAw-1:0]    rptr;
  logic [QCntW-1:0]  fill;

  function automatic logic [QAw-1:0] wrap_inc(logic [QAw-1:0] p);
    return (p == QAw'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.full  = (fill == QCntW'(QDepth));
  assign stat.empty = (fill == '0);
  assign rdata      = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wrap_inc(wptr);
      if (pop)  rptr <= wrap_inc(rptr);
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

endmodule

// ===== hw/rtl/p2p_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts correspondences, counts the set and forms coordinate differences.
module p2p_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  p2p_pkg::item_t   item,
  input  p2p_pkg::q_stat_t q_stat,
  output logic             busy,
  output logic             push,
  output p2p_pkg::entry_t  entry
);
  import p2p_pkg::*;

  logic [CntW-1:0] count;
  logic            keep;

  function automatic logic signed [DiffW-1:0] diff(logic [31:0] s, logic [31:0] t);
    logic signed [31:0] a;
    logic signed [31:0] b;
    a = coord_ext(s);
    b = coord_ext(t);
    return DiffW'(a) - DiffW'(b);
  endfunction

  assign busy = q_stat.full;
  assign push = start && !q_stat.full;
  assign keep = (count < CntW'(MaxPairs));

  always_comb begin
    entry.d_x   = diff(item.src_x, item.tgt_x);
    entry.d_y   = diff(item.src_y, item.tgt_y);
    entry.d_z   = diff(item.src_z, item.tgt_z);
    entry.n_x   = item.norm_x;
    entry.n_y   = item.norm_y;
    entry.n_z   = item.norm_z;
    entry.keep  = keep;
    entry.last  = item.is_last;
    entry.count = keep ? count + 1'b1 : count;
  end

  // Count restarts after the word that closes a set.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      if (item.is_last) count <= '0;
      else if (keep)    count <= count + 1'b1;
    end
  end

endmodule

// ===== hw/rtl/p2p_final.sv =====
`timescale 1ns / 1ps
// Closing unit: bit-serial divide of the sum by the count, then bit-serial square root.
module p2p_final (
  input  logic              clk,
  input  logic              rst,
  input  p2p_pkg::fin_req_t req,
  output p2p_pkg::fin_rsp_t rsp
);
  import p2p_pkg::*;

  fin_state_t       state;
  fin_state_t       state_next;
  logic [StepW-1:0] step;
  logic [63:0]      dvd;
  logic [CntW-1:0]  dvs;
  logic [CntW-1:0]  rem;
  logic [CntW:0]    rem_sh;
  logic             div_ge;
  logic [34:0]      srem;
  logic [34:0]      srem_sh;
  logic [34:0]      trial;
  logic             sq_ge;
  logic [31:0]      root;
  logic             done;

  assign rem_sh  = {rem, dvd[63]};
  assign div_ge  = (rem_sh >= {1'b0, dvs});
  assign srem_sh = {srem[32:0], dvd[63:62]};
  assign trial   = {1'b0, root, 2'b01};
  assign sq_ge   = (srem_sh >= trial);

  assign rsp.done = done;
  assign rsp.root = root;

  always_ff @(posedge clk) begin
    if (rst) state <= FIN_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      FIN_IDLE: if (req.start) state_next = FIN_DIV;
      FIN_DIV:  if (step == StepW'(DivSteps - 1)) state_next = FIN_SQRT;
      FIN_SQRT: if (step == StepW'(SqrtSteps - 1)) state_next = FIN_IDLE;
      default:  state_next = FIN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= (state == FIN_SQRT) && (step == StepW'(SqrtSteps - 1));
      case (state)
        FIN_IDLE: step <= '0;
        FIN_DIV:  step <= (step == StepW'(DivSteps - 1)) ? '0 : step + 1'b1;
        FIN_SQRT: step <= step + 1'b1;
        default:  step <= '0;
      endcase
    end
  end

  // The quotient shifts into the dividend register and is then consumed two bits a step.
  always_ff @(posedge clk) begin
    case (state)
      FIN_IDLE: begin
        if (req.start) begin
          dvd <= req.sum;
          dvs <= req.count;
          rem <= '0;
        end
        srem <= '0;
        root <= root;
      end
      FIN_DIV: begin
        rem  <= div_ge ? CntW'(rem_sh - {1'b0, dvs}) : CntW'(rem_sh);
        dvd  <= {dvd[62:0], div_ge};
        srem <= '0;
        root <= '0;
      end
      FIN_SQRT: begin
        dvd  <= {dvd[61:0], 2'b00};
        srem <= sq_ge ? srem_sh - trial : srem_sh;
        root <= {root[30:0], sq_ge};
      end
      default: begin
        srem <= '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/p2p_back.sv =====
`timescale 1ns / 1ps
// Accumulator: residual by a shared multiplier, rounding, squaring, saturating sum, set close.
module p2p_back (
  input  logic              clk,
  input  logic              rst,
  input  p2p_pkg::q_stat_t  q_stat,
  input  p2p_pkg::entry_t   rdata,
  output logic              pop,
  output p2p_pkg::fin_req_t fin_req,
  input  p2p_pkg::fin_rsp_t fin_rsp,
  output logic              done,
  output p2p_pkg::result_t  result
);
  import p2p_pkg::*;

  back_state_t            state;
  back_state_t            state_next;
  entry_t                 ent;
  logic [1:0]             k;
  logic signed [DiffW-1:0] d_sel;
  logic signed [NormW-1:0] n_sel;
  logic signed [DiffW+NormW-1:0] prod;
  logic signed [AccW-1:0] acc;
  logic signed [AccW-1:0] t_rnd;
  logic signed [35:0]     r_rnd;
  logic [35:0]            r_mag;
  logic [31:0]            mag;
  logic                   big;
  logic [63:0]            sq;
  logic [64:0]            sum_wide;
  logic [63:0]            sum;
  logic                   ovf;

  always_comb begin
    case (k)
      2'd0:    begin d_sel = ent.d_x; n_sel = ent.n_x; end
      2'd1:    begin d_sel = ent.d_y; n_sel = ent.n_y; end
      default: begin d_sel = ent.d_z; n_sel = ent.n_z; end
    endcase
  end

  assign prod     = d_sel * n_sel;
  // Round half up to Q16.16.
  assign t_rnd    = acc + AccW'(16384);
  assign r_rnd    = 36'(t_rnd >>> 15);
  assign r_mag    = r_rnd[35] ? 36'(-r_rnd) : 36'(r_rnd);
  assign sum_wide = {1'b0, sum} + {1'b0, sq};

  assign fin_req.start = (state == BK_LAUNCH);
  assign fin_req.sum   = sum;
  assign fin_req.count = ent.count;

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          if (rdata.keep)      state_next = BK_MUL;
          else if (rdata.last) state_next = BK_LAUNCH;
        end
      end
      BK_MUL:    if (k == 2'd2) state_next = BK_ROUND;
      BK_ROUND:  state_next = BK_SQ;
      BK_SQ:     state_next = BK_ADD;
      BK_ADD:    state_next = ent.last ? BK_LAUNCH : BK_IDLE;
      BK_LAUNCH: state_next = BK_WAIT;
      BK_WAIT:   if (fin_rsp.done) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum  <= '0;
      ovf  <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        BK_IDLE: begin
          k <= '0;
          // Drop words past the set limit but flag them.
          if (!q_stat.empty && !rdata.keep) ovf <= 1'b1;
        end
        BK_MUL: k <= k + 1'b1;
        BK_ADD: begin
          if (big || sum_wide[64]) begin
            sum <= '1;
            ovf <= 1'b1;
          end else begin
            sum <= sum_wide[63:0];
          end
        end
        BK_WAIT: begin
          if (fin_rsp.done) begin
            done <= 1'b1;
            sum  <= '0;
            ovf  <= 1'b0;
          end
        end
        default: k <= k;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (!q_stat.empty) ent <= rdata;
        acc <= '0;
      end
      BK_MUL:   acc <= acc + AccW'(prod);
      BK_ROUND: begin
        mag <= r_mag[31:0];
        big <= |r_mag[35:32];
      end
      BK_SQ:    sq <= mag * mag;
      BK_WAIT: begin
        if (fin_rsp.done) begin
          result.rms_error  <= fin_rsp.root;
          result.pair_count <= 17'(ent.count);
          result.saturated  <= ovf;
        end
      end
      default: acc <= acc;
    endcase
  end

endmodule

// ===== hw/rtl/point_to_plane_rmse.sv =====
`timescale 1ns / 1ps
// Top level of the point-to-plane RMS error block.
//
//  channel  | direction | handshake          | word
//  ---------+-----------+--------------------+------------------------------
//  item     | in        | start && !busy     | src, tgt, normal, is_last
//  result   | out       | done (one cycle)   | rms_error, pair_count, saturated
//
// A counted word passes through the accumulator in order: take, three multiply steps through
// one 33x16 multiplier, round, square, add; a dropped word is only taken and flagged.
// The word that closes a set then adds 64 divide steps, 32 square root steps and a handoff.
// A 2-word queue lets the front keep accepting while the accumulator works; busy is queue full.
// Reset clears the queue, the counters, the sum and the saturation flag.
// Results leave as one-cycle pulses on done.
module point_to_plane_rmse (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  p2p_pkg::item_t   item,
  output logic             done,
  output p2p_pkg::result_t result
);
  import p2p_pkg::*;

  q_stat_t  q_stat;
  entry_t   q_wdata;
  entry_t   q_rdata;
  logic     q_push;
  logic     q_pop;
  fin_req_t fin_req;
  fin_rsp_t fin_rsp;

  p2p_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .q_stat (q_stat),
    .busy   (busy),
    .push   (q_push),
    .entry  (q_wdata)
  );

  p2p_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  p2p_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_stat  (q_stat),
    .rdata   (q_rdata),
    .pop     (q_pop),
    .fin_req (fin_req),
    .fin_rsp (fin_rsp),
    .done    (done),
    .result  (result)
  );

  p2p_final u_final (
    .clk (clk),
    .rst (rst),
    .req (fin_req),
    .rsp (fin_rsp)
  );

endmodule

// ===== hw/rtl/p2p_check.sv =====
`timescale 1ns / 1ps
// Port-level checks for the point-to-plane RMS error block, bound to the top level.
module p2p_check (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input p2p_pkg::item_t   item,
  input logic             done,
  input p2p_pkg::result_t result
);
  import p2p_pkg::*;

  // Reset leaves the queue empty and no result pending.
  a_reset_clear: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("busy or done after reset");

  // The closing divide and square root steps lie between results, so results never come back to back.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two results in adjacent cycles");

  // Every set counts at least one word, so its pair count is never zero.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> result.pair_count != 17'd0)
    else $error("result with zero pair count");

  // A queue that is not full turns full only by accepting a word; without start it stays not full.
  a_busy_needs_push: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !busy)
    else $error("queue filled with no word accepted");

endmodule

bind point_to_plane_rmse p2p_check u_check (.*);
